// ===== rtl/core/mkenc_pkg.sv =====
// Shared types, constants and the Morse symbol ROM for the keyer encoder.
package mkenc_pkg;

    localparam int DATA_W        = 8;
    localparam int DASH_W        = 4;
    localparam int DUR_W         = 12;
    localparam int CHAR_W        = 7;
    localparam int PADDLE_W      = 2;
    localparam int UNITS_W       = 4;
    localparam int SYM_MAX       = 6;
    localparam int SYM_CNT_W     = 3;
    localparam int SEG_IDX_W     = 4;
    localparam int CFG_ADDR_W    = 1;
    localparam int S_TDATA_W     = 16;
    localparam int M_TDATA_W     = 16;
    localparam int FIFO_DEPTH    = 2;

    localparam logic [CFG_ADDR_W-1:0] REG_DOT_LENGTH = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DASH_UNITS = 1'd1;

    localparam logic [DATA_W-1:0] DOT_LENGTH_RST = 8'd100;
    localparam logic [DASH_W-1:0] DASH_UNITS_RST = 4'd3;

    localparam logic FUNC_CHAR   = 1'b0;
    localparam logic FUNC_PADDLE = 1'b1;

    localparam logic [UNITS_W-1:0] UNITS_DOT        = 4'd1;
    localparam logic [UNITS_W-1:0] UNITS_LETTER_GAP = 4'd4;
    localparam logic [UNITS_W-1:0] UNITS_WORD_GAP   = 4'd7;

    localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'h20;

    typedef enum logic [1:0] {
        TAIL_NONE,
        TAIL_LETTER,
        TAIL_WORD
    } tail_t;

    // sym is left aligned: bit 5 is the first symbol, 1 = dash
    typedef struct packed {
        logic [SYM_CNT_W-1:0] n_sym;
        logic [SYM_MAX-1:0]   sym;
        tail_t                tail;
    } job_t;

    typedef struct packed {
        logic                 found;
        logic [SYM_CNT_W-1:0] n_sym;
        logic [SYM_MAX-1:0]   sym;
    } rom_t;

    function automatic rom_t morse_rom(input logic [CHAR_W-1:0] ch);
        rom_t r;
        r.found = 1'b1;
        r.n_sym = '0;
        r.sym   = '0;
        case ({1'b0, ch})
            "A": begin r.n_sym = 3'd2; r.sym = 6'b010000; end
            "B": begin r.n_sym = 3'd4; r.sym = 6'b100000; end
            "C": begin r.n_sym = 3'd4; r.sym = 6'b101000; end
            "D": begin r.n_sym = 3'd3; r.sym = 6'b100000; end
            "E": begin r.n_sym = 3'd1; r.sym = 6'b000000; end
            "F": begin r.n_sym = 3'd4; r.sym = 6'b001000; end
            "G": begin r.n_sym = 3'd3; r.sym = 6'b110000; end
            "H": begin r.n_sym = 3'd4; r.sym = 6'b000000; end
            "I": begin r.n_sym = 3'd2; r.sym = 6'b000000; end
            "J": begin r.n_sym = 3'd4; r.sym = 6'b011100; end
            "K": begin r.n_sym = 3'd3; r.sym = 6'b101000; end
            "L": begin r.n_sym = 3'd4; r.sym = 6'b010000; end
            "M": begin r.n_sym = 3'd2; r.sym = 6'b110000; end
            "N": begin r.n_sym = 3'd2; r.sym = 6'b100000; end
            "O": begin r.n_sym = 3'd3; r.sym = 6'b111000; end
            "P": begin r.n_sym = 3'd4; r.sym = 6'b011000; end
            "Q": begin r.n_sym = 3'd4; r.sym = 6'b110100; end
            "R": begin r.n_sym = 3'd3; r.sym = 6'b010000; end
            "S": begin r.n_sym = 3'd3; r.sym = 6'b000000; end
            "T": begin r.n_sym = 3'd1; r.sym = 6'b100000; end
            "U": begin r.n_sym = 3'd3; r.sym = 6'b001000; end
            "V": begin r.n_sym = 3'd4; r.sym = 6'b000100; end
            "W": begin r.n_sym = 3'd3; r.sym = 6'b011000; end
            "X": begin r.n_sym = 3'd4; r.sym = 6'b100100; end
            "Y": begin r.n_sym = 3'd4; r.sym = 6'b101100; end
            "Z": begin r.n_sym = 3'd4; r.sym = 6'b110000; end
            "0": begin r.n_sym = 3'd5; r.sym = 6'b111110; end
            "1": begin r.n_sym = 3'd5; r.sym = 6'b011110; end
            "2": begin r.n_sym = 3'd5; r.sym = 6'b001110; end
            "3": begin r.n_sym = 3'd5; r.sym = 6'b000110; end
            "4": begin r.n_sym = 3'd5; r.sym = 6'b000010; end
            "5": begin r.n_sym = 3'd5; r.sym = 6'b000000; end
            "6": begin r.n_sym = 3'd5; r.sym = 6'b100000; end
            "7": begin r.n_sym = 3'd5; r.sym = 6'b110000; end
            "8": begin r.n_sym = 3'd5; r.sym = 6'b111000; end
            "9": begin r.n_sym = 3'd5; r.sym = 6'b111100; end
            "/": begin r.n_sym = 3'd5; r.sym = 6'b100100; end
            "?": begin r.n_sym = 3'd6; r.sym = 6'b001100; end
            ".": begin r.n_sym = 3'd6; r.sym = 6'b010101; end
            ",": begin r.n_sym = 3'd6; r.sym = 6'b110011; end
            default: r.found = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/mkenc_front.sv =====
// Front end: accepts requests and turns them into symbol jobs.
module mkenc_front (
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [mkenc_pkg::CHAR_W-1:0]    character,
    input  logic [mkenc_pkg::PADDLE_W-1:0]  paddle,
    input  logic                            func,
    input  logic                            q_full,
    output logic                            q_push,
    output mkenc_pkg::job_t                 q_job
);

    mkenc_pkg::rom_t rom;
    logic            job_ok;

    assign rom = mkenc_pkg::morse_rom(character);

    always_comb begin
        q_job  = '{n_sym: '0, sym: '0, tail: mkenc_pkg::TAIL_NONE};
        job_ok = 1'b0;
        if (func == mkenc_pkg::FUNC_PADDLE) begin
            job_ok = |paddle;
            case (paddle)
                2'b01:   q_job.n_sym = 3'd1;
                2'b10: begin
                    q_job.n_sym = 3'd1;
                    q_job.sym   = 6'b100000;
                end
                2'b11: begin
                    q_job.n_sym = 3'd2;
                    q_job.sym   = 6'b010000;
                end
                default: q_job.n_sym = '0;
            endcase
        end else if (character == mkenc_pkg::CHAR_SPACE) begin
            job_ok     = 1'b1;
            q_job.tail = mkenc_pkg::TAIL_WORD;
        end else begin
            job_ok      = rom.found;
            q_job.n_sym = rom.n_sym;
            q_job.sym   = rom.sym;
            q_job.tail  = mkenc_pkg::TAIL_LETTER;
        end
    end

    // requests that yield nothing are taken and dropped
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full && job_ok;

endmodule

// ===== rtl/core/mkenc_fifo.sv =====
// Small job queue between front end and segment sequencer (DEPTH >= 2).
module mkenc_fifo #(
    parameter int DEPTH = mkenc_pkg::FIFO_DEPTH
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  mkenc_pkg::job_t push_job,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output mkenc_pkg::job_t head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mkenc_pkg::job_t  mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_job  = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== rtl/core/mkenc_back.sv =====
// Back end: steps through a job one segment per cycle into the output register, unless m_tready stalls it.
module mkenc_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [mkenc_pkg::DATA_W-1:0]    dot_length,
    input  logic [mkenc_pkg::DASH_W-1:0]    dash_units,
    input  logic                            q_not_empty,
    input  mkenc_pkg::job_t                 q_job,
    output logic                            q_pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic                            key_down,
    output logic [mkenc_pkg::DUR_W-1:0]     duration_ms,
    output logic                            m_tlast
);

    localparam int SEG_IDX_W = mkenc_pkg::SEG_IDX_W;

    logic [SEG_IDX_W-1:0]           seg_idx_reg, seg_idx_next;
    logic                           valid_reg, valid_next;
    logic                           key_reg;
    logic [mkenc_pkg::DUR_W-1:0]    dur_reg;
    logic                           last_reg;

    logic [SEG_IDX_W-1:0]           sym_segs;
    logic [SEG_IDX_W-1:0]           total;
    logic                           in_sym;
    logic [mkenc_pkg::SYM_CNT_W-1:0] sym_i, bit_i;
    logic                           is_dash;
    logic                           seg_key;
    logic                           seg_last;
    logic [mkenc_pkg::UNITS_W-1:0]  units;
    logic [mkenc_pkg::DUR_W-1:0]    product;
    logic                           advance;

    assign sym_segs = {q_job.n_sym, 1'b0};
    assign total    = sym_segs + SEG_IDX_W'(q_job.tail != mkenc_pkg::TAIL_NONE);
    assign in_sym   = seg_idx_reg < sym_segs;
    assign sym_i    = seg_idx_reg[SEG_IDX_W-1:1];
    assign bit_i    = 3'(mkenc_pkg::SYM_MAX - 1) - sym_i;
    assign is_dash  = q_job.sym[bit_i];
    assign seg_key  = in_sym && seg_idx_reg[0];
    assign seg_last = (seg_idx_reg == total - 1'b1);
    assign advance  = q_not_empty && (!valid_reg || m_tready);
    assign q_pop    = advance && seg_last;

    always_comb begin
        if (!in_sym) begin
            units = (q_job.tail == mkenc_pkg::TAIL_WORD) ? mkenc_pkg::UNITS_WORD_GAP
                                                         : mkenc_pkg::UNITS_LETTER_GAP;
        end else if (seg_key && is_dash) begin
            units = dash_units;
        end else begin
            units = mkenc_pkg::UNITS_DOT;
        end
    end

    assign product = units * dot_length;

    always_comb begin
        seg_idx_next = seg_idx_reg;
        valid_next   = valid_reg;
        if (m_tready) begin
            valid_next = 1'b0;
        end
        if (advance) begin
            valid_next   = 1'b1;
            seg_idx_next = seg_last ? '0 : seg_idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seg_idx_reg <= '0;
            valid_reg   <= 1'b0;
        end else begin
            seg_idx_reg <= seg_idx_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            key_reg  <= seg_key;
            dur_reg  <= product;
            last_reg <= seg_last;
        end
    end

    assign m_tvalid    = valid_reg;
    assign key_down    = key_reg;
    assign duration_ms = dur_reg;
    assign m_tlast     = last_reg;

endmodule

// ===== rtl/core/morse_keyer_encoder_top.sv =====
// Morse keyer encoder top level: config registers, front end, job queue, sequencer.
// The first segment of a request passes the job queue and then the output register to m_tvalid.
// Throughput: one segment per cycle while m_tready does not stall the output; a request
// yields 1 to 13 segments, paced by the sequencer's single output register.
// Requests yielding nothing are taken while the queue is not full and dropped; the job queue holds FIFO_DEPTH jobs.
// Reset (aresetn low, synchronous) empties queue and output, loads dot 100 ms, dash 3.
module morse_keyer_encoder_top #(
    parameter int FIFO_DEPTH = mkenc_pkg::FIFO_DEPTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [mkenc_pkg::S_TDATA_W-1:0]     s_tdata,  // character[6:0], paddle[8:7], zero
    input  logic                                s_tuser,  // func
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [mkenc_pkg::M_TDATA_W-1:0]     m_tdata,  // key_down[0], duration_ms[12:1], zero
    output logic                                m_tlast,
    input  logic                                cfg_we,
    input  logic [mkenc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [mkenc_pkg::DATA_W-1:0]        cfg_wdata
);

    logic [mkenc_pkg::DATA_W-1:0] dot_length_reg;
    logic [mkenc_pkg::DASH_W-1:0] dash_units_reg;

    logic                         q_push, q_full, q_pop, q_not_empty;
    mkenc_pkg::job_t              push_job, head_job;
    logic                         key_down;
    logic [mkenc_pkg::DUR_W-1:0]  duration_ms;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dot_length_reg <= mkenc_pkg::DOT_LENGTH_RST;
            dash_units_reg <= mkenc_pkg::DASH_UNITS_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                mkenc_pkg::REG_DOT_LENGTH: dot_length_reg <= cfg_wdata;
                mkenc_pkg::REG_DASH_UNITS:
                    dash_units_reg <= cfg_wdata[mkenc_pkg::DASH_W-1:0];
                default: ;
            endcase
        end
    end

    mkenc_front u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .character (s_tdata[mkenc_pkg::CHAR_W-1:0]),
        .paddle    (s_tdata[mkenc_pkg::CHAR_W +: mkenc_pkg::PADDLE_W]),
        .func      (s_tuser),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (push_job)
    );

    mkenc_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_job  (push_job),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_job  (head_job)
    );

    mkenc_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .dot_length  (dot_length_reg),
        .dash_units  (dash_units_reg),
        .q_not_empty (q_not_empty),
        .q_job       (head_job),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .key_down    (key_down),
        .duration_ms (duration_ms),
        .m_tlast     (m_tlast)
    );

    assign m_tdata = {
        (mkenc_pkg::M_TDATA_W - mkenc_pkg::DUR_W - 1)'(0),
        duration_ms,
        key_down
    };

endmodule

// ===== rtl/core/mkenc_checker.sv =====
// Port-level checker for the Morse keyer encoder, bound to the top level.
module mkenc_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [mkenc_pkg::M_TDATA_W-1:0]     m_tdata,
    input logic                                m_tlast,
    input logic                                cfg_we,
    input logic [mkenc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input logic [mkenc_pkg::DATA_W-1:0]        cfg_wdata
);

    logic [mkenc_pkg::DATA_W-1:0] dot_shadow_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dot_shadow_reg <= mkenc_pkg::DOT_LENGTH_RST;
        end else if (cfg_we && cfg_addr == mkenc_pkg::REG_DOT_LENGTH) begin
            dot_shadow_reg <= cfg_wdata;
        end
    end

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[mkenc_pkg::M_TDATA_W-1:mkenc_pkg::DUR_W+1] == '0)
        else $error("padding bits of result not zero");

    a_inner_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast && !m_tdata[0]
            |-> m_tdata[mkenc_pkg::DUR_W:1] == mkenc_pkg::DUR_W'(dot_shadow_reg))
        else $error("inner key-up gap is not one dot long");

endmodule

bind morse_keyer_encoder_top mkenc_checker u_mkenc_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
);
